### hdl/bqwd_pkg.sv
// Shared widths, reset values, register codes and types for the window dispatcher.
package bqwd_pkg;

  // Field widths fixed by the item and register formats.
  localparam int TIME_W     = 20;
  localparam int DUR_W      = 12;
  localparam int WIN_OUT_W  = 5;
  localparam int NUMWIN_W   = 6;
  localparam int QDEPTH_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Default sizes of the window table and of each waiting line.
  localparam int WINDOWS_DEF = 32;
  localparam int DEPTH_DEF   = 16;

  // Saturation limit for times and the largest job duration.
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam int                DUR_MAX  = (1 << DUR_W) - 1;

  // Register reset values.
  localparam logic [NUMWIN_W-1:0] NUM_WINDOWS_RST = NUMWIN_W'(1);
  localparam logic [QDEPTH_W-1:0] QUEUE_DEPTH_RST = QDEPTH_W'(1);
  localparam logic [TIME_W-1:0]   CLOSE_TIME_RST  = TIME_W'(540);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_WINDOWS = 2'd0,
    REG_QUEUE_DEPTH = 2'd1,
    REG_CLOSE_TIME  = 2'd2
  } cfg_reg_t;

  // Configuration register contents as seen by the sequencer.
  typedef struct packed {
    logic [NUMWIN_W-1:0] num_windows;
    logic [QDEPTH_W-1:0] queue_depth;
    logic [TIME_W-1:0]   close_time;
  } cfg_regs_t;

endpackage

### hdl/bqwd_intf.sv
// Handshake channel interfaces for jobs, results and configuration writes.
interface bqwd_job_if;
  import bqwd_pkg::*;
  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] duration;
  modport source (output valid, output duration, input ready);
  modport sink   (input valid, input duration, output ready);
endinterface

interface bqwd_res_if;
  import bqwd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [WIN_OUT_W-1:0] window;
  logic [TIME_W-1:0]    start_time;
  logic [TIME_W-1:0]    finish_time;
  logic                 refused;
  modport source (output valid, output window, output start_time, output finish_time,
                  output refused, input ready);
  modport sink   (input valid, input window, input start_time, input finish_time,
                  input refused, output ready);
endinterface

interface bqwd_cfg_if;
  import bqwd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/bqwd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bqwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/bqwd_cfg.sv
// Configuration register file written over the configuration channel.
module bqwd_cfg (
  input  logic                clk,
  input  logic                rst,
  bqwd_cfg_if.sink            cfg,
  output bqwd_pkg::cfg_regs_t regs
);
  import bqwd_pkg::*;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Decode the register index and store the low bits of the write data.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.num_windows <= NUM_WINDOWS_RST;
      regs.queue_depth <= QUEUE_DEPTH_RST;
      regs.close_time  <= CLOSE_TIME_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_NUM_WINDOWS: regs.num_windows <= cfg.data[NUMWIN_W-1:0];
        REG_QUEUE_DEPTH: regs.queue_depth <= cfg.data[QDEPTH_W-1:0];
        REG_CLOSE_TIME:  regs.close_time  <= cfg.data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/bqwd_seq.sv
// Dispatch sequencer: round-robin fill, earliest-head scan and window update.
module bqwd_seq #(
  parameter int WINDOWS = bqwd_pkg::WINDOWS_DEF,
  parameter int DEPTH   = bqwd_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bqwd_pkg::cfg_regs_t cfg_regs,
  bqwd_job_if.sink            job,
  bqwd_res_if.source          result,
  // Window table port: {next_free, tail, head} per window.
  output logic                win_we,
  output logic [((WINDOWS > 1) ? $clog2(WINDOWS) : 1)-1:0] win_waddr,
  output logic [bqwd_pkg::TIME_W + 2*((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] win_wdata,
  output logic [((WINDOWS > 1) ? $clog2(WINDOWS) : 1)-1:0] win_raddr,
  input  logic [bqwd_pkg::TIME_W + 2*((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] win_rdata,
  // Line store port: finish times, addressed by {window, slot}.
  output logic                line_we,
  output logic [((WINDOWS > 1) ? $clog2(WINDOWS) : 1) + ((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]
                              line_waddr,
  output logic [bqwd_pkg::TIME_W-1:0] line_wdata,
  output logic [((WINDOWS > 1) ? $clog2(WINDOWS) : 1) + ((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]
                              line_raddr,
  input  logic [bqwd_pkg::TIME_W-1:0] line_rdata
);
  import bqwd_pkg::*;

  localparam int WIW = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
  localparam int NW  = $clog2(WINDOWS + 1);
  localparam int DW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW  = $clog2(DEPTH + 1);
  localparam int SW  = MW + 1;
  localparam int FCW = $clog2(WINDOWS * DEPTH + 1);
  localparam int EW  = TIME_W + 2 * DW;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_READ = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t             state;
  logic [FCW-1:0]     fill_count;
  logic [WIW-1:0]     fill_window;
  logic [WINDOWS-1:0] vld;
  logic               res_valid;
  logic               p1;
  logic               p2;

  logic [DUR_W-1:0]   dur;
  logic [WIW-1:0]     w;
  logic               pop;
  logic [NW-1:0]      scan_cnt;
  logic [WIW-1:0]     i1;
  logic [WIW-1:0]     i2;
  logic [TIME_W-1:0]  best;
  logic               first;

  logic [WIN_OUT_W-1:0] res_window;
  logic [TIME_W-1:0]    res_start;
  logic [TIME_W-1:0]    res_finish;
  logic                 res_refused;

  logic [NW-1:0]      n_eff;
  logic [MW-1:0]      m_eff;
  logic [FCW-1:0]     fill_limit;
  logic               fill_mode;
  logic [WIW-1:0]     fw_wrap;
  logic [NW-1:0]      fw_inc;
  logic [WIW-1:0]     fw_next;
  logic               accept;
  logic               scan_issue;
  logic               scan_done;
  logic [DW-1:0]      scan_head;
  logic [EW-1:0]      entry;
  logic [TIME_W-1:0]  start;
  logic [TIME_W:0]    sum;
  logic [TIME_W-1:0]  finish;
  logic [DW-1:0]      head;
  logic [DW-1:0]      tail;
  logic [DW-1:0]      head_new;
  logic [DW-1:0]      tail_new;
  logic               upd_fire;

  // Next ring slot, wrapping at the line length in use.
  function automatic logic [DW-1:0] adv_slot(input logic [DW-1:0] s, input logic [MW-1:0] m);
    logic [SW-1:0] t;
    t = SW'(s) + SW'(1);
    return (t >= SW'(m)) ? '0 : DW'(t);
  endfunction

  // Effective window count and line length, clamped to the built sizes.
  always_comb begin
    if (cfg_regs.num_windows == '0) begin
      n_eff = NW'(1);
    end else if (int'(cfg_regs.num_windows) > WINDOWS) begin
      n_eff = NW'(WINDOWS);
    end else begin
      n_eff = NW'(cfg_regs.num_windows);
    end
    if (cfg_regs.queue_depth == '0) begin
      m_eff = MW'(1);
    end else if (int'(cfg_regs.queue_depth) > DEPTH) begin
      m_eff = MW'(DEPTH);
    end else begin
      m_eff = MW'(cfg_regs.queue_depth);
    end
  end

  // Round-robin fill decision and next fill window.
  assign fill_limit = FCW'(n_eff) * FCW'(m_eff);
  assign fill_mode  = fill_count < fill_limit;
  assign fw_wrap    = (NW'(fill_window) >= n_eff) ? '0 : fill_window;
  assign fw_inc     = NW'(fw_wrap) + NW'(1);
  assign fw_next    = (fw_inc >= n_eff) ? '0 : WIW'(fw_inc);

  assign job.ready  = (state == ST_IDLE);
  assign accept     = job.valid && (state == ST_IDLE);

  // Scan pipeline: table read, then line head read, then compare.
  assign scan_issue = (state == ST_SCAN) && (scan_cnt < n_eff);
  assign scan_done  = (state == ST_SCAN) && (scan_cnt == n_eff) && !p1 && !p2;
  assign scan_head  = vld[i1] ? win_rdata[DW-1:0] : '0;
  assign win_raddr  = (state == ST_SCAN) ? scan_cnt[WIW-1:0] : w;
  assign line_raddr = {i1, scan_head};

  // Update of the chosen window; a window never written reads as all zero.
  assign entry    = vld[w] ? win_rdata : '0;
  assign start    = entry[EW-1 -: TIME_W];
  assign tail     = entry[2*DW-1 -: DW];
  assign head     = entry[DW-1:0];
  assign sum      = {1'b0, start} + (TIME_W + 1)'(dur);
  assign finish   = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  assign head_new = pop ? adv_slot(head, m_eff) : head;
  assign tail_new = adv_slot(tail, m_eff);
  assign upd_fire = (state == ST_UPD) && (!res_valid || result.ready);

  assign win_we     = upd_fire;
  assign win_waddr  = w;
  assign win_wdata  = {finish, tail_new, head_new};
  assign line_we    = upd_fire;
  assign line_waddr = {w, tail};
  assign line_wdata = finish;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill_count  <= '0;
      fill_window <= '0;
      vld         <= '0;
      res_valid   <= 1'b0;
      p1          <= 1'b0;
      p2          <= 1'b0;
    end else begin
      p1 <= scan_issue;
      p2 <= p1;
      if (upd_fire) begin
        res_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (fill_mode) begin
              fill_window <= fw_next;
              fill_count  <= fill_count + FCW'(1);
              state       <= ST_READ;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (upd_fire) begin
            vld[w] <= 1'b1;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item working registers and the earliest-head compare.
  always_ff @(posedge clk) begin
    if (accept) begin
      dur      <= job.duration;
      scan_cnt <= '0;
      first    <= 1'b1;
      pop      <= !fill_mode;
      if (fill_mode) begin
        w <= fw_wrap;
      end
    end
    if (scan_issue) begin
      scan_cnt <= scan_cnt + NW'(1);
    end
    i1 <= scan_cnt[WIW-1:0];
    i2 <= i1;
    if (p2 && (first || (line_rdata < best))) begin
      best  <= line_rdata;
      w     <= i2;
      first <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (upd_fire) begin
      res_window  <= WIN_OUT_W'(w);
      res_start   <= start;
      res_finish  <= finish;
      res_refused <= (start >= cfg_regs.close_time);
    end
  end

  assign result.valid       = res_valid;
  assign result.window      = res_window;
  assign result.start_time  = res_start;
  assign result.finish_time = res_finish;
  assign result.refused     = res_refused;

endmodule

### hdl/bounded_queue_window_dispatcher_top.sv
// Top level of the earliest-finish job dispatcher over windows with bounded lines.
// The result is registered after the window update, both while lines fill round-robin and
// once lines are full and the scan runs over the n windows in use; one job at a time.
// The next job is taken after the window update, which waits while the result is stalled.
// The scan reads one window's line head per cycle through the window table and line store.
// Reset clears the control state, the registers and the window table's valid bits.
module bounded_queue_window_dispatcher_top #(
  parameter int WINDOWS = bqwd_pkg::WINDOWS_DEF,
  parameter int DEPTH   = bqwd_pkg::DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  bqwd_job_if.sink   job,
  bqwd_res_if.source result,
  bqwd_cfg_if.sink   cfg
);
  import bqwd_pkg::*;

  localparam int WIW = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
  localparam int DW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW  = TIME_W + 2 * DW;
  localparam int LAW = WIW + DW;

  cfg_regs_t         cfg_regs;
  logic              win_we;
  logic [WIW-1:0]    win_waddr;
  logic [EW-1:0]     win_wdata;
  logic [WIW-1:0]    win_raddr;
  logic [EW-1:0]     win_rdata;
  logic              line_we;
  logic [LAW-1:0]    line_waddr;
  logic [TIME_W-1:0] line_wdata;
  logic [LAW-1:0]    line_raddr;
  logic [TIME_W-1:0] line_rdata;

  // Configuration registers.
  bqwd_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  // Sequencer.
  bqwd_seq #(
    .WINDOWS (WINDOWS),
    .DEPTH   (DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_regs   (cfg_regs),
    .job        (job),
    .result     (result),
    .win_we     (win_we),
    .win_waddr  (win_waddr),
    .win_wdata  (win_wdata),
    .win_raddr  (win_raddr),
    .win_rdata  (win_rdata),
    .line_we    (line_we),
    .line_waddr (line_waddr),
    .line_wdata (line_wdata),
    .line_raddr (line_raddr),
    .line_rdata (line_rdata)
  );

  // Per-window next-free time and ring pointers.
  bqwd_ram #(
    .WIDTH (EW),
    .DEPTH (WINDOWS)
  ) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  // Queued finish times, one ring per window.
  bqwd_ram #(
    .WIDTH (TIME_W),
    .DEPTH (WINDOWS << DW)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

endmodule

### hdl/bqwd_checker.sv
// Port-level checks on the dispatcher, bound to its top level.
module bqwd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           job_valid,
  input logic                           job_ready,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic [bqwd_pkg::WIN_OUT_W-1:0] res_window,
  input logic [bqwd_pkg::TIME_W-1:0]    res_start,
  input logic [bqwd_pkg::TIME_W-1:0]    res_finish,
  input logic                           res_refused
);
  import bqwd_pkg::*;

  // A job transfer makes the block busy for at least the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    job_valid && job_ready |=> !job_ready)
    else $error("job input still ready right after a transfer");

  // A new result appears only when the block was busy the cycle before.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(!job_ready))
    else $error("result appeared without a job in progress");

  // Finish time never precedes start time and exceeds it by at most the largest duration.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_finish >= res_start) &&
                  ((res_finish - res_start) <= TIME_W'(DUR_MAX)))
    else $error("finish time inconsistent with start time");

  // A stalled result holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_window) && $stable(res_start) &&
                                $stable(res_finish) && $stable(res_refused))
    else $error("stalled result changed");

endmodule

bind bounded_queue_window_dispatcher_top bqwd_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .job_valid   (job.valid),
  .job_ready   (job.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_window  (result.window),
  .res_start   (result.start_time),
  .res_finish  (result.finish_time),
  .res_refused (result.refused)
);

### test/tb.sv
// Self-checking testbench for the window dispatcher: predicts each job's placement and checks it.
module tb;
  import bqwd_pkg::*;

  localparam int NWIN  = WINDOWS_DEF;
  localparam int NSLOT = DEPTH_DEF;
  localparam int PRINT_CAP = 30;

  // Register index outside the map; a write there must leave every register alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Ready patterns of the result receiver.
  typedef enum int {RX_OPEN, RX_BUSY, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    logic [WIN_OUT_W-1:0] window;
    logic [TIME_W-1:0]    start_time;
    logic [TIME_W-1:0]    finish_time;
    logic                 refused;
  } dispatch_t;

  // Dispatch predictor plus the queue of results still owed by the block.
  class dispatch_scoreboard;
    logic [NUMWIN_W-1:0] num_windows;
    logic [QDEPTH_W-1:0] queue_depth;
    logic [TIME_W-1:0]   close_time;
    logic [TIME_W-1:0]   next_free [NWIN];
    logic [TIME_W-1:0]   finish_line [NWIN*NSLOT];
    bit                  slot_written [NWIN*NSLOT];
    int unsigned         line_head [NWIN];
    int unsigned         line_tail [NWIN];
    int unsigned         fill_count;
    int unsigned         fill_window;
    dispatch_t           owed_q[$];
    int unsigned         errors, jobs, reg_writes, scan_picks, refusals, saturations;

    function new();
      num_windows = NUM_WINDOWS_RST;
      queue_depth = QUEUE_DEPTH_RST;
      close_time  = CLOSE_TIME_RST;
      foreach (next_free[i]) next_free[i] = '0;
      foreach (finish_line[i]) begin
        finish_line[i]  = '0;
        slot_written[i] = 1'b0;
      end
      foreach (line_head[i]) begin
        line_head[i] = 0;
        line_tail[i] = 0;
      end
      fill_count  = 0;
      fill_window = 0;
      errors      = 0;
      jobs        = 0;
      reg_writes  = 0;
      scan_picks  = 0;
      refusals    = 0;
      saturations = 0;
    endfunction

    function int unsigned active_windows();
      if (num_windows == 0) return 1;
      if (int'(num_windows) > NWIN) return NWIN;
      return int'(num_windows);
    endfunction

    function int unsigned active_depth();
      if (queue_depth == 0) return 1;
      if (int'(queue_depth) > NSLOT) return NSLOT;
      return int'(queue_depth);
    endfunction

    function int unsigned next_slot(int unsigned s, int unsigned lim);
      return (s + 1 >= lim) ? 0 : s + 1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_NUM_WINDOWS: num_windows = data[NUMWIN_W-1:0];
        REG_QUEUE_DEPTH: queue_depth = data[QDEPTH_W-1:0];
        REG_CLOSE_TIME:  close_time  = data[TIME_W-1:0];
        default: ;
      endcase
    endfunction

    function bit all_written();
      foreach (slot_written[i]) if (!slot_written[i]) return 1'b0;
      return 1'b1;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Works out where an accepted job goes and queues the result it must produce.
    function void note_job(logic [DUR_W-1:0] dur);
      int unsigned       n, m, w, addr;
      logic [TIME_W-1:0] best, start, finish;
      logic [TIME_W:0]   total;
      dispatch_t         owed;
      n = active_windows();
      m = active_depth();
      if (fill_count < n * m) begin
        // Lines still have room: plain round-robin.
        if (fill_window >= n) fill_window = 0;
        w = fill_window;
        fill_window = next_slot(fill_window, n);
        fill_count++;
      end else begin
        // Earliest head finish wins; the strict compare keeps the lowest window on a tie.
        w = 0;
        best = finish_line[line_head[0] % NSLOT];
        for (int unsigned i = 1; i < n; i++) begin
          if (finish_line[i * NSLOT + line_head[i] % NSLOT] < best) begin
            best = finish_line[i * NSLOT + line_head[i] % NSLOT];
            w = i;
          end
        end
        line_head[w] = next_slot(line_head[w] % NSLOT, m);
        scan_picks++;
      end
      start  = next_free[w];
      total  = {1'b0, start} + (TIME_W+1)'(dur);
      finish = (total > {1'b0, TIME_MAX}) ? TIME_MAX : total[TIME_W-1:0];
      next_free[w] = finish;
      addr = w * NSLOT + line_tail[w] % NSLOT;
      finish_line[addr]  = finish;
      slot_written[addr] = 1'b1;
      line_tail[w] = next_slot(line_tail[w] % NSLOT, m);
      owed.window      = WIN_OUT_W'(w);
      owed.start_time  = start;
      owed.finish_time = finish;
      owed.refused     = (start >= close_time);
      if (owed.refused) refusals++;
      if (finish == TIME_MAX) saturations++;
      jobs++;
      owed_q.push_back(owed);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("[%0t] check failed: %s", $time, msg);
    endtask

    // Compares one transferred result with the oldest owed one.
    task check_result(dispatch_t got);
      dispatch_t owed;
      if (owed_q.size() == 0) begin
        report("result with no job waiting for one");
        return;
      end
      owed = owed_q.pop_front();
      if (got.window !== owed.window)
        report($sformatf("window %0d, expected %0d", got.window, owed.window));
      if (got.start_time !== owed.start_time)
        report($sformatf("start_time %0d, expected %0d", got.start_time, owed.start_time));
      if (got.finish_time !== owed.finish_time)
        report($sformatf("finish_time %0d, expected %0d", got.finish_time, owed.finish_time));
      if (got.refused !== owed.refused)
        report($sformatf("refused %0b, expected %0b", got.refused, owed.refused));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  bqwd_job_if job_ch();
  bqwd_res_if res_ch();
  bqwd_cfg_if cfg_ch();

  bounded_queue_window_dispatcher_top dut (
    .clk    (clk),
    .rst    (rst),
    .job    (job_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  dispatch_scoreboard sb;
  dispatch_t          seen_result;
  int unsigned        results_seen = 0;
  int unsigned        burst_left = 0;
  int unsigned        hold_left = 0;
  int unsigned        hold_count = 0;
  int unsigned        mode_left = 0;
  rx_mode_t           rx_mode = RX_OPEN;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result monitor: every transfer goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen_result.window      = res_ch.window;
      seen_result.start_time  = res_ch.start_time;
      seen_result.finish_time = res_ch.finish_time;
      seen_result.refused     = res_ch.refused;
      sb.check_result(seen_result);
      results_seen++;
    end
  end

  // Result receiver: open, busy and sparse stretches, plus two long hold-offs.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        res_ch.ready = 1'b0;
        hold_left--;
      end else if (hold_count < 2 && results_seen >= 300 + 700 * hold_count) begin
        res_ch.ready = 1'b0;
        hold_left = 399;
        hold_count++;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN: res_ch.ready = 1'b1;
          RX_BUSY: res_ch.ready = ($urandom_range(0, 3) != 0);
          default: res_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offers one job in the current burst, opening a new burst after a random gap.
  task automatic send_job(input logic [DUR_W-1:0] dur);
    if (burst_left == 0) begin
      job_ch.valid = 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    job_ch.valid    = 1'b1;
    job_ch.duration = dur;
    do @(posedge clk); while (!job_ch.ready);
    sb.note_job(dur);
    @(negedge clk);
    job_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Picks new sizes and a closing time, favoring the edges of each range.
  task automatic reconfigure();
    logic [CFG_DATA_W-1:0] d;
    bit                    wrote;
    wrote = 1'b0;
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 7))
        0: d = '0;
        1: d = CFG_DATA_W'(1);
        2: d = CFG_DATA_W'(NWIN);
        3: d = CFG_DATA_W'(63);
        4: d = CFG_DATA_W'($urandom);
        default: d = CFG_DATA_W'($urandom_range(1, NWIN));
      endcase
      write_reg(REG_NUM_WINDOWS, d);
      wrote = 1'b1;
    end
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 7))
        0: d = '0;
        1: d = CFG_DATA_W'(1);
        2: d = CFG_DATA_W'(NSLOT);
        3: d = CFG_DATA_W'(31);
        4: d = CFG_DATA_W'($urandom);
        default: d = CFG_DATA_W'($urandom_range(1, NSLOT));
      endcase
      write_reg(REG_QUEUE_DEPTH, d);
      wrote = 1'b1;
    end
    if (!wrote || $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 5))
        0: d = '0;
        1: d = TIME_MAX;
        2: d = CLOSE_TIME_RST;
        3: d = CFG_DATA_W'($urandom);
        default: d = CFG_DATA_W'($urandom_range(0, 300000));
      endcase
      write_reg(REG_CLOSE_TIME, d);
    end
    if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
  endtask

  function automatic logic [DUR_W-1:0] rand_duration();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DUR_W'(DUR_MAX);
      2: return DUR_W'(1) << $urandom_range(0, DUR_W - 1);
      3, 4, 5: return DUR_W'($urandom);
      default: return DUR_W'($urandom_range(1, 255));
    endcase
  endfunction

  // Stimulus: directed jobs, a full fill of every line, random phases, then saturation.
  initial begin
    int unsigned k;
    sb = new();
    rst = 1'b1;
    job_ch.valid    = 1'b0;
    job_ch.duration = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Reset sizes: one window, one slot; zero and longest jobs, start crosses closing time.
    send_job('0);
    send_job('0);
    send_job(DUR_W'(DUR_MAX));
    send_job(DUR_W'(1));
    send_job(12'hAAA);
    send_job(12'h555);
    send_job(12'h800);
    wait_idle();

    // Largest sizes. Equal first jobs make 31 line heads tie at the first scans.
    // Running until every slot holds a finish time keeps later size changes safe.
    write_reg(REG_NUM_WINDOWS, CFG_DATA_W'(NWIN));
    write_reg(REG_QUEUE_DEPTH, CFG_DATA_W'(NSLOT));
    write_reg(REG_CLOSE_TIME, TIME_MAX);
    k = 0;
    while (k < 560 || !sb.all_written()) begin
      send_job((k < 64) ? DUR_W'(100) : rand_duration());
      k++;
    end

    // Random phases, each under new register values.
    while (sb.jobs < 1150) begin
      wait_idle();
      reconfigure();
      repeat ($urandom_range(15, 100)) send_job(rand_duration());
    end

    // One window fed the longest jobs until its time pins at the limit.
    wait_idle();
    write_reg(REG_NUM_WINDOWS, CFG_DATA_W'(1));
    write_reg(REG_QUEUE_DEPTH, CFG_DATA_W'($urandom_range(1, NSLOT)));
    while (sb.next_free[0] != TIME_MAX) send_job(DUR_W'(DUR_MAX));
    repeat (4) send_job(rand_duration());

    wait_idle();
    repeat (60) @(negedge clk);
    if (sb.pending() != 0) sb.report("jobs left without a result");
    $display("Covered %0d jobs and %0d register writes, up to %0d windows of %0d slots.",
             sb.jobs, sb.reg_writes, NWIN, NSLOT);
    $display("%0d jobs went to the earliest line, %0d were refused, %0d ended at the limit.",
             sb.scan_picks, sb.refusals, sb.saturations);
    if (sb.errors == 0) begin
      $display("bounded_queue_window_dispatcher_top: match");
    end else begin
      $display("bounded_queue_window_dispatcher_top: mismatch");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #30_000_000;
    $display("bounded_queue_window_dispatcher_top: mismatch");
    $finish;
  end

endmodule
